// ===== rtl/rotate_point_about_axis_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the rotate_point_about_axis block
// Simulation builds get concurrent assertions; synthesis builds get nothing.
// ---------------------------------------------------------------------------
`ifndef ROTATE_POINT_ABOUT_AXIS_DEFINES_SVH
`define ROTATE_POINT_ABOUT_AXIS_DEFINES_SVH
`ifndef SYNTHESIS
`define RPA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rotate_point_about_axis: assertion failed");
`define RPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rotate_point_about_axis: assertion failed");
`else
`define RPA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define RPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/rpa_pkg.sv =====
// ---------------------------------------------------------------------------
// rpa_pkg
// Shared constants and types of the axis rotation block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpa_pkg;

    localparam int COORD_WIDTH_DEF   = 32;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 18;

    localparam int AXIS_WIDTH      = 18;
    localparam int ANGLE_WIDTH     = 32;
    localparam int CORDIC_ONE_BITS = 30;

    // Inverse CORDIC gain with 1.0 at 2^30.
    localparam logic [31:0] CORDIC_GAIN = 32'd652032875;

    // Arctangent of 2^-i in binary-angle units (2^32 is a full turn).
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef enum logic [2:0] {
        REG_PIVOT_X = 3'd0,
        REG_PIVOT_Y = 3'd1,
        REG_PIVOT_Z = 3'd2,
        REG_AXIS_X  = 3'd3,
        REG_AXIS_Y  = 3'd4,
        REG_AXIS_Z  = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rpa_cordic.sv =====
// ---------------------------------------------------------------------------
// rpa_cordic
// Pipelined rotation-mode CORDIC giving cosine and sine of a binary angle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rotate_point_about_axis_defines.svh"

module rpa_cordic #(
    parameter int FRAC_BITS = rpa_pkg::FRAC_BITS_DEF,
    parameter int STAGES    = rpa_pkg::CORDIC_STAGES_DEF,
    parameter int TAG_W     = 3 * rpa_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [31:0]                in_angle,
    input  wire logic [TAG_W-1:0]           in_tag,
    output logic                            out_valid,
    output logic signed [FRAC_BITS+1:0]     out_cos,
    output logic signed [FRAC_BITS+1:0]     out_sin,
    output logic [TAG_W-1:0]                out_tag
);

    localparam int XW   = 33;
    localparam int ZW   = 33;
    localparam int NST  = STAGES + 2;
    localparam int CSW  = FRAC_BITS + 2;
    localparam int SH   = rpa_pkg::CORDIC_ONE_BITS - FRAC_BITS;
    localparam int RXW  = XW + 1 - SH;
    localparam int HALF = 1 << (SH - 1);
    localparam int ONE  = 1 << FRAC_BITS;
    localparam logic signed [RXW-1:0] ONE_R = RXW'(ONE);
    localparam logic signed [CSW-1:0] ONE_C = CSW'(ONE);
    localparam logic signed [ZW-1:0]  Z_OFF = ZW'(1 << 29);

    logic [NST-1:0]          v_reg;
    logic signed [XW-1:0]    x_reg   [STAGES+1];
    logic signed [XW-1:0]    y_reg   [STAGES+1];
    logic signed [ZW-1:0]    z_reg   [STAGES+1];
    rpa_pkg::quad_t          q_reg   [STAGES+1];
    logic [TAG_W-1:0]        tag_reg [STAGES+1];
    logic [31:0]             sh_ang;

    logic signed [XW:0]      xa, ya;
    logic signed [RXW-1:0]   xr, yr, xc, yc;
    logic signed [CSW-1:0]   c_v, s_v;
    logic signed [CSW-1:0]   cos_next, sin_next;
    logic signed [CSW-1:0]   cos_reg, sin_reg;
    logic [TAG_W-1:0]        tag_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    // Shift by an eighth turn so the residual angle sits in [-1/8, 1/8).
    assign sh_ang = in_angle + 32'h2000_0000;

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= XW'(rpa_pkg::CORDIC_GAIN);
            y_reg[0]   <= '0;
            z_reg[0]   <= signed'(ZW'(sh_ang[29:0])) - Z_OFF;
            q_reg[0]   <= rpa_pkg::quad_t'(sh_ang[31:30]);
            tag_reg[0] <= in_tag;
            for (int i = 0; i < STAGES; i++) begin
                if (z_reg[i][ZW-1]) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ZW'({1'b0, rpa_pkg::ATAN_TURNS[i]});
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ZW'({1'b0, rpa_pkg::ATAN_TURNS[i]});
                end
                q_reg[i+1]   <= q_reg[i];
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    // Round to FRAC_BITS, clamp to [-1, 1], then apply the quadrant.
    always_comb begin
        xa = (XW+1)'(x_reg[STAGES]) + (XW+1)'(HALF);
        ya = (XW+1)'(y_reg[STAGES]) + (XW+1)'(HALF);
        xr = RXW'(xa >>> SH);
        yr = RXW'(ya >>> SH);
        xc = (xr > ONE_R) ? ONE_R : ((xr < -ONE_R) ? -ONE_R : xr);
        yc = (yr > ONE_R) ? ONE_R : ((yr < -ONE_R) ? -ONE_R : yr);
        c_v = CSW'(xc);
        s_v = CSW'(yc);
        case (q_reg[STAGES])
            rpa_pkg::QUAD_0: begin
                cos_next = c_v;
                sin_next = s_v;
            end
            rpa_pkg::QUAD_90: begin
                cos_next = -s_v;
                sin_next = c_v;
            end
            rpa_pkg::QUAD_180: begin
                cos_next = -c_v;
                sin_next = -s_v;
            end
            default: begin
                cos_next = s_v;
                sin_next = -c_v;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg     <= cos_next;
            sin_reg     <= sin_next;
            tag_out_reg <= tag_reg[STAGES];
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_cos   = cos_reg;
    assign out_sin   = sin_reg;
    assign out_tag   = tag_out_reg;

    `RPA_ASSERT_IMPLIES(a_cos_range, aclk, aresetn, out_valid, (out_cos <= ONE_C) && (out_cos >= -ONE_C))
    `RPA_ASSERT_IMPLIES(a_sin_range, aclk, aresetn, out_valid, (out_sin <= ONE_C) && (out_sin >= -ONE_C))

endmodule

`default_nettype wire

// ===== rtl/rpa_geom.sv =====
// ---------------------------------------------------------------------------
// rpa_geom
// Pipelined axis projection, cross product and rotation with saturation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpa_geom #(
    parameter int COORD_WIDTH = rpa_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rpa_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     en,
    input  wire logic                                     in_valid,
    input  wire logic [2:0][COORD_WIDTH-1:0]              in_pos,
    input  wire logic signed [FRAC_BITS+1:0]              in_cos,
    input  wire logic signed [FRAC_BITS+1:0]              in_sin,
    input  wire logic [2:0][COORD_WIDTH-1:0]              pivot,
    input  wire logic [2:0][rpa_pkg::AXIS_WIDTH-1:0]      axis,
    output logic                                          out_valid,
    output logic [2:0][COORD_WIDTH-1:0]                   out_rot
);

    localparam int C     = COORD_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int AW    = rpa_pkg::AXIS_WIDTH;
    localparam int CSW   = F + 2;
    localparam int NG    = 10;
    localparam int HALF  = 1 << (F - 1);
    localparam int DW    = C + 1;
    localparam int PW    = DW + AW;
    localparam int SW    = PW + 3;
    localparam int DOTW  = SW - F;
    localparam int CPW   = DOTW + AW;
    localparam int CW    = CPW + 1 - F;
    localparam int AAW   = rpa_pkg::max2(DW, CW) + 1;
    localparam int XPW   = AAW + AW;
    localparam int XDW   = XPW + 2;
    localparam int BW    = XDW - F;
    localparam int MAW   = AAW + CSW;
    localparam int MBW   = BW + CSW;
    localparam int MSW   = rpa_pkg::max2(MAW, MBW) + 2;
    localparam int DISPW = MSW - F;
    localparam int QCW   = rpa_pkg::max2(C, CW) + 1;
    localparam int RW    = rpa_pkg::max2(QCW, DISPW) + 1;

    logic [NG-1:0]            v_reg;
    logic signed [AW-1:0]     u_s      [3];
    logic signed [CSW-1:0]    cos_reg  [7];
    logic signed [CSW-1:0]    sin_reg  [7];
    logic signed [DW-1:0]     d_reg    [4][3];
    logic signed [PW-1:0]     pr_reg   [3];
    logic signed [SW-1:0]     dsum;
    logic signed [DOTW-1:0]   dot_next, dot_reg;
    logic signed [CPW-1:0]    cp_reg   [3];
    logic signed [CPW:0]      cpr      [3];
    logic signed [CW-1:0]     c_next   [3];
    logic signed [AAW-1:0]    a_next   [3];
    logic signed [CW-1:0]     c_reg    [4][3];
    logic signed [AAW-1:0]    a_reg    [3][3];
    logic signed [XPW-1:0]    xp_reg   [6];
    logic signed [XDW-1:0]    bd       [3];
    logic signed [BW-1:0]     b_next   [3];
    logic signed [BW-1:0]     b_reg    [3];
    logic signed [MAW-1:0]    ma_reg   [3];
    logic signed [MBW-1:0]    mb_reg   [3];
    logic signed [MSW-1:0]    ms       [3];
    logic signed [DISPW-1:0]  disp_next[3];
    logic signed [DISPW-1:0]  disp_reg [3];
    logic signed [QCW-1:0]    qc_reg   [3];
    logic signed [RW-1:0]     r_sum    [3];
    logic [2:0][C-1:0]        rot_next;
    logic [2:0][C-1:0]        rot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NG-2:0], in_valid};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            u_s[i] = signed'(axis[i]);
        end
    end

    // Rounding steps between the product registers.
    always_comb begin
        dsum = SW'(pr_reg[0]) + SW'(pr_reg[1]) + SW'(pr_reg[2]) + SW'(HALF);
        dot_next = DOTW'(dsum >>> F);
        for (int i = 0; i < 3; i++) begin
            cpr[i]    = (CPW+1)'(cp_reg[i]) + (CPW+1)'(HALF);
            c_next[i] = CW'(cpr[i] >>> F);
            a_next[i] = AAW'(d_reg[3][i]) - AAW'(c_next[i]);
        end
        bd[0] = XDW'(xp_reg[0]) - XDW'(xp_reg[1]) + XDW'(HALF);
        bd[1] = XDW'(xp_reg[2]) - XDW'(xp_reg[3]) + XDW'(HALF);
        bd[2] = XDW'(xp_reg[4]) - XDW'(xp_reg[5]) + XDW'(HALF);
        for (int i = 0; i < 3; i++) begin
            b_next[i]    = BW'(bd[i] >>> F);
            ms[i]        = MSW'(ma_reg[i]) + MSW'(mb_reg[i]) + MSW'(HALF);
            disp_next[i] = DISPW'(ms[i] >>> F);
            r_sum[i]     = RW'(qc_reg[i]) + RW'(disp_reg[i]);
            if ((&r_sum[i][RW-1:C-1]) || !(|r_sum[i][RW-1:C-1])) begin
                rot_next[i] = r_sum[i][C-1:0];
            end else if (r_sum[i][RW-1]) begin
                rot_next[i] = {1'b1, {(C-1){1'b0}}};
            end else begin
                rot_next[i] = {1'b0, {(C-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg[0] <= in_cos;
            sin_reg[0] <= in_sin;
            for (int k = 1; k < 7; k++) begin
                cos_reg[k] <= cos_reg[k-1];
                sin_reg[k] <= sin_reg[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                // Offset from the pivot, then its projection onto the axis.
                d_reg[0][i] <= DW'(signed'(in_pos[i])) - DW'(signed'(pivot[i]));
                pr_reg[i]   <= PW'(d_reg[0][i]) * PW'(u_s[i]);
                d_reg[1][i] <= d_reg[0][i];
                d_reg[2][i] <= d_reg[1][i];
                cp_reg[i]   <= CPW'(dot_reg) * CPW'(u_s[i]);
                d_reg[3][i] <= d_reg[2][i];
                c_reg[0][i] <= c_next[i];
                a_reg[0][i] <= a_next[i];
                c_reg[1][i] <= c_reg[0][i];
                a_reg[1][i] <= a_reg[0][i];
                b_reg[i]    <= b_next[i];
                c_reg[2][i] <= c_reg[1][i];
                a_reg[2][i] <= a_reg[1][i];
                ma_reg[i]   <= MAW'(a_reg[2][i]) * MAW'(cos_reg[6]);
                mb_reg[i]   <= MBW'(b_reg[i]) * MBW'(sin_reg[6]);
                c_reg[3][i] <= c_reg[2][i];
                disp_reg[i] <= disp_next[i];
                qc_reg[i]   <= QCW'(signed'(pivot[i])) + QCW'(c_reg[3][i]);
            end
            dot_reg   <= dot_next;
            // Cross product u x A.
            xp_reg[0] <= XPW'(u_s[1]) * XPW'(a_reg[0][2]);
            xp_reg[1] <= XPW'(u_s[2]) * XPW'(a_reg[0][1]);
            xp_reg[2] <= XPW'(u_s[2]) * XPW'(a_reg[0][0]);
            xp_reg[3] <= XPW'(u_s[0]) * XPW'(a_reg[0][2]);
            xp_reg[4] <= XPW'(u_s[0]) * XPW'(a_reg[0][1]);
            xp_reg[5] <= XPW'(u_s[1]) * XPW'(a_reg[0][0]);
            rot_reg   <= rot_next;
        end
    end

    assign out_valid = v_reg[NG-1];
    assign out_rot   = rot_reg;

endmodule

`default_nettype wire

// ===== rtl/rotate_point_about_axis.sv =====
// ---------------------------------------------------------------------------
// rotate_point_about_axis
// Rotates a stream of 3D points about a configured axis line by a per-item
// angle, using a pipelined CORDIC and a pipelined Rodrigues datapath.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Payload
//   s_        in         s_tvalid / s_tready       pos_x, pos_y, pos_z, turn_angle
//   m_        out        m_tvalid / m_tready       rot_x, rot_y, rot_z
//   APB       in         psel, penable, pready     pivot_x..z, axis_x..z
//
// One item can enter every clock cycle while s_tready is high. An accepted
// input item passes through the sine/cosine pipeline, the geometry pipeline
// and the output register before its result appears on m_.
// The whole pipeline advances together; a one-entry skid register behind the
// output register absorbs the item in flight when m_tready drops, and
// s_tready is simply the skid register being empty, so it is registered.
// Reset is synchronous and active low and clears all valid bits; the axis
// resets to +z and the pivot to the origin.
// Configuration must be written only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "rotate_point_about_axis_defines.svh"

module rotate_point_about_axis #(
    parameter int COORD_WIDTH   = rpa_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS     = rpa_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = rpa_pkg::CORDIC_STAGES_DEF,
    parameter int APB_W         = (COORD_WIDTH > 32) ? 64 : 32,
    parameter int ADDR_W        = ((APB_W > 32) ? 3 : 2) + 3,
    parameter int S_W           = ((3 * COORD_WIDTH + rpa_pkg::ANGLE_WIDTH + 7) / 8) * 8,
    parameter int M_W           = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Input items.
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // s_tdata from bit 0: pos_x, pos_y, pos_z, turn_angle (32 bits), zero fill.
    input  wire logic [S_W-1:0]     s_tdata,
    // Result items.
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // m_tdata from bit 0: rot_x, rot_y, rot_z, zero fill.
    output logic [M_W-1:0]          m_tdata,
    // Configuration port.
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]        prdata,
    output logic                    pready
);

    localparam int C      = COORD_WIDTH;
    localparam int AW     = rpa_pkg::AXIS_WIDTH;
    localparam int CSW    = FRAC_BITS + 2;
    localparam int STEP   = (APB_W > 32) ? 3 : 2;
    localparam int TAG_W  = 3 * C;

    // Configuration registers.
    logic [C-1:0]           pivot_x_reg, pivot_y_reg, pivot_z_reg;
    logic [AW-1:0]          axis_x_reg, axis_y_reg, axis_z_reg;
    logic                   cfg_wr;
    logic [2:0]             cfg_idx;
    logic [2:0][C-1:0]      pivot_bus;
    logic [2:0][AW-1:0]     axis_bus;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[ADDR_W-1:STEP];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pivot_x_reg <= '0;
            pivot_y_reg <= '0;
            pivot_z_reg <= '0;
            axis_x_reg  <= '0;
            axis_y_reg  <= '0;
            axis_z_reg  <= AW'(1 << FRAC_BITS);
        end else if (cfg_wr) begin
            case (rpa_pkg::reg_idx_t'(cfg_idx))
                rpa_pkg::REG_PIVOT_X: pivot_x_reg <= pwdata[C-1:0];
                rpa_pkg::REG_PIVOT_Y: pivot_y_reg <= pwdata[C-1:0];
                rpa_pkg::REG_PIVOT_Z: pivot_z_reg <= pwdata[C-1:0];
                rpa_pkg::REG_AXIS_X:  axis_x_reg  <= pwdata[AW-1:0];
                rpa_pkg::REG_AXIS_Y:  axis_y_reg  <= pwdata[AW-1:0];
                rpa_pkg::REG_AXIS_Z:  axis_z_reg  <= pwdata[AW-1:0];
                default: ;
            endcase
        end
    end

    // Reads return the register sign-extended to the bus width.
    always_comb begin
        case (rpa_pkg::reg_idx_t'(cfg_idx))
            rpa_pkg::REG_PIVOT_X: prdata = APB_W'(signed'(pivot_x_reg));
            rpa_pkg::REG_PIVOT_Y: prdata = APB_W'(signed'(pivot_y_reg));
            rpa_pkg::REG_PIVOT_Z: prdata = APB_W'(signed'(pivot_z_reg));
            rpa_pkg::REG_AXIS_X:  prdata = APB_W'(signed'(axis_x_reg));
            rpa_pkg::REG_AXIS_Y:  prdata = APB_W'(signed'(axis_y_reg));
            rpa_pkg::REG_AXIS_Z:  prdata = APB_W'(signed'(axis_z_reg));
            default:              prdata = '0;
        endcase
    end

    assign pivot_bus = {pivot_z_reg, pivot_y_reg, pivot_x_reg};
    assign axis_bus  = {axis_z_reg, axis_y_reg, axis_x_reg};

    // Pipeline advance: everything moves unless the skid register is full.
    logic                   en;
    logic                   skid_v_reg;
    logic                   out_v_reg;
    logic [TAG_W-1:0]       skid_reg;
    logic [TAG_W-1:0]       out_reg;
    logic                   m_fire;

    assign en       = ~skid_v_reg;
    assign s_tready = en;

    // The point rides along the CORDIC pipeline as a tag.
    logic                   cor_valid;
    logic signed [CSW-1:0]  cor_cos, cor_sin;
    logic [TAG_W-1:0]       cor_tag;

    rpa_cordic #(
        .FRAC_BITS (FRAC_BITS),
        .STAGES    (CORDIC_STAGES),
        .TAG_W     (TAG_W)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_angle  (s_tdata[TAG_W +: rpa_pkg::ANGLE_WIDTH]),
        .in_tag    (s_tdata[TAG_W-1:0]),
        .out_valid (cor_valid),
        .out_cos   (cor_cos),
        .out_sin   (cor_sin),
        .out_tag   (cor_tag)
    );

    logic                   geo_valid;
    logic [2:0][C-1:0]      geo_rot;

    rpa_geom #(
        .COORD_WIDTH (C),
        .FRAC_BITS   (FRAC_BITS)
    ) u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cor_valid),
        .in_pos    (cor_tag),
        .in_cos    (cor_cos),
        .in_sin    (cor_sin),
        .pivot     (pivot_bus),
        .axis      (axis_bus),
        .out_valid (geo_valid),
        .out_rot   (geo_rot)
    );

    // Output register with a one-entry skid buffer behind it.
    assign m_fire = out_v_reg & m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (m_fire) begin
                skid_v_reg <= 1'b0;
            end
        end else if (geo_valid) begin
            if (!out_v_reg || m_fire) begin
                out_v_reg <= 1'b1;
            end else begin
                skid_v_reg <= 1'b1;
            end
        end else if (m_fire) begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (m_fire) begin
                out_reg <= skid_reg;
            end
        end else if (geo_valid) begin
            if (!out_v_reg || m_fire) begin
                out_reg <= geo_rot;
            end else begin
                skid_reg <= geo_rot;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = M_W'(out_reg);

    `RPA_ASSERT_IMPLIES(a_skid_needs_out, aclk, aresetn, skid_v_reg, out_v_reg)
    `RPA_ASSERT_IMPLIES(a_skid_fills_on_stall, aclk, aresetn, $rose(skid_v_reg), $past(out_v_reg && !m_tready))
    `RPA_ASSERT_NEXT(a_axis_write_keeps_pivot, aclk, aresetn, cfg_wr && (cfg_idx == 3'(rpa_pkg::REG_AXIS_X) || cfg_idx == 3'(rpa_pkg::REG_AXIS_Y) || cfg_idx == 3'(rpa_pkg::REG_AXIS_Z)), $stable(pivot_bus))

endmodule

`default_nettype wire

// ===== sim/tb_rotate_point_about_axis.sv =====
// ---------------------------------------------------------------------------
// Testbench for rotate_point_about_axis
// Streams points and angles through the block under several pivot and axis
// settings, predicts each rotated point with a bit-exact model of the
// CORDIC and the Rodrigues datapath, and checks every result in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rotate_point_about_axis;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int STAGES = 18;
    localparam int LATENCY = STAGES + 13;
    localparam longint CYCLE_LIMIT = 400000;

    // Packed with x in the lowest bits, as on the data buses.
    typedef struct packed {
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } point_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // s_tdata from bit 0: pos_x, pos_y, pos_z, turn_angle.
    logic [127:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // m_tdata from bit 0: rot_x, rot_y, rot_z.
    logic [95:0] m_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Shadow copy of the configuration, used by the predictor.
    longint pivot_q [3];
    longint axis_u [3];

    point_t rotated_pending [$];
    int errors = 0;
    longint cycles = 0;
    bit stall_free = 1'b0;
    int m_wait = 0;

    rotate_point_about_axis u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Round half up, then arithmetic shift.
    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo,
                                        input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Rotation-mode CORDIC with quadrant folding; yields cosine and sine.
    task automatic cordic_sincos(input logic [31:0] angle, output longint cv,
                                 output longint sv);
        logic [31:0] shifted;
        rpa_pkg::quad_t quad;
        longint x, y, z, dx, dy, c, s;
        shifted = angle + 32'h2000_0000;
        quad = rpa_pkg::quad_t'(shifted[31:30]);
        z = longint'({2'b00, shifted[29:0]}) - (64'sd1 <<< 29);
        x = rpa_pkg::CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z < 0) begin
                x += dx; y -= dy; z += rpa_pkg::ATAN_TURNS[i];
            end else begin
                x -= dx; y += dy; z -= rpa_pkg::ATAN_TURNS[i];
            end
        end
        c = clamp_to(round_shift(x, rpa_pkg::CORDIC_ONE_BITS - FB), -(64'sd1 <<< FB),
                     64'sd1 <<< FB);
        s = clamp_to(round_shift(y, rpa_pkg::CORDIC_ONE_BITS - FB), -(64'sd1 <<< FB),
                     64'sd1 <<< FB);
        case (quad)
            rpa_pkg::QUAD_0:   begin cv = c;  sv = s;  end
            rpa_pkg::QUAD_90:  begin cv = -s; sv = c;  end
            rpa_pkg::QUAD_180: begin cv = -c; sv = -s; end
            default:           begin cv = s;  sv = -c; end
        endcase
    endtask

    task automatic predict_rotation(input point_t pos, input logic [31:0] angle,
                                    output point_t rot);
        longint d [3], c [3], a [3], b [3], dot, cs, sn, disp, sum;
        logic [31:0] r [3];
        d[0] = longint'($signed(pos.x)) - pivot_q[0];
        d[1] = longint'($signed(pos.y)) - pivot_q[1];
        d[2] = longint'($signed(pos.z)) - pivot_q[2];
        dot = round_shift(d[0] * axis_u[0] + d[1] * axis_u[1] + d[2] * axis_u[2], FB);
        for (int i = 0; i < 3; i++) begin
            c[i] = round_shift(dot * axis_u[i], FB);
            a[i] = d[i] - c[i];
        end
        b[0] = round_shift(axis_u[1] * a[2] - axis_u[2] * a[1], FB);
        b[1] = round_shift(axis_u[2] * a[0] - axis_u[0] * a[2], FB);
        b[2] = round_shift(axis_u[0] * a[1] - axis_u[1] * a[0], FB);
        cordic_sincos(angle, cs, sn);
        for (int i = 0; i < 3; i++) begin
            disp = round_shift(a[i] * cs + b[i] * sn, FB);
            sum = pivot_q[i] + c[i] + disp;
            r[i] = 32'(clamp_to(sum, -(64'sd1 <<< (CW - 1)), (64'sd1 <<< (CW - 1)) - 1));
        end
        rot = '{x: r[0], y: r[1], z: r[2]};
    endtask

    task automatic write_reg(input rpa_pkg::reg_idx_t idx, input logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx) << 2; pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx <= rpa_pkg::REG_PIVOT_Z)
            pivot_q[idx] = longint'($signed(value));
        else
            axis_u[idx - rpa_pkg::REG_AXIS_X] = longint'($signed(value[17:0]));
    endtask

    // Drives one item after a random gap (none in stall-free phases) and waits for its acceptance.
    task automatic send_point(input point_t pos, input logic [31:0] angle);
        point_t rot;
        int gap;
        gap = stall_free ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {angle, pos.z, pos.y, pos.x};
        do @(posedge aclk); while (!s_tready);
        predict_rotation(pos, angle, rot);
        rotated_pending.push_back(rot);
        @(negedge aclk);
    endtask

    // Lets the pipeline empty out so that configuration can change.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (rotated_pending.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    function automatic point_t any_point();
        return '{x: $urandom, y: $urandom, z: $urandom};
    endfunction

    // Mostly moderate coordinates, sometimes anything up to the full range.
    function automatic point_t pick_point();
        point_t p;
        p = any_point();
        if ($urandom_range(0, 3) != 0) begin
            p.x = 32'($signed(p.x) >>> $urandom_range(4, 14));
            p.y = 32'($signed(p.y) >>> $urandom_range(4, 14));
            p.z = 32'($signed(p.z) >>> $urandom_range(4, 14));
        end
        return p;
    endfunction

    function automatic logic [17:0] pick_unit_axis();
        case ($urandom_range(0, 3))
            0: return 18'sd65536;
            1: return -18'sd65536;
            2: return 18'sd0;
            default: return 18'($urandom_range(0, 131072)) - 18'sd65536;
        endcase
    endfunction

    task automatic test_default_axis;
        point_t extremes [4];
        logic [31:0] angles [8];
        extremes[0] = '{x: 32'h7FFF_FFFF, y: 32'h7FFF_FFFF, z: 32'h8000_0000};
        extremes[1] = '{x: 32'h8000_0000, y: 32'h8000_0000, z: 32'h7FFF_FFFF};
        extremes[2] = '{x: 32'h0001_0000, y: 32'h0, z: 32'h0};
        extremes[3] = '{x: 32'hFFFF_FFFF, y: 32'h0, z: 32'hFFFF_FFFF};
        angles = '{32'h0, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000,
                   32'h2000_0000, 32'h1FFF_FFFF, 32'hFFFF_FFFF, 32'hE000_0000};
        foreach (angles[i])
            foreach (extremes[j])
                if (j == i % 4 || i < 2) send_point(extremes[j], angles[i]);
    endtask

    // Pivot far out pushes results past the coordinate range.
    task automatic test_saturation;
        write_reg(rpa_pkg::REG_PIVOT_X, 32'h7FFF_0000);
        write_reg(rpa_pkg::REG_PIVOT_Y, 32'h8000_0000);
        write_reg(rpa_pkg::REG_PIVOT_Z, 32'h7FFF_FFFF);
        send_point('{x: 32'h8000_0000, y: 32'h7FFF_FFFF, z: 32'h8000_0000}, 32'h8000_0000);
        send_point('{x: 32'h8000_0000, y: 32'h7FFF_FFFF, z: 32'h0}, 32'h4000_0000);
        drain();
        // Zero axis, and then an axis that is not of unit length.
        write_reg(rpa_pkg::REG_AXIS_Z, 18'd0);
        send_point('{x: 32'h0123_4567, y: 32'h8000_0000, z: 32'h7FFF_FFFF}, 32'h1234_5678);
        drain();
        write_reg(rpa_pkg::REG_AXIS_X, 18'sd65536);
        write_reg(rpa_pkg::REG_AXIS_Y, -18'sd65536);
        write_reg(rpa_pkg::REG_AXIS_Z, 18'sd65536);
        send_point('{x: 32'h7FFF_FFFF, y: 32'h8000_0000, z: 32'h7FFF_FFFF}, 32'h5555_5555);
        send_point('{x: 32'h8000_0000, y: 32'h7FFF_FFFF, z: 32'h8000_0000}, 32'hAAAA_AAAA);
        drain();
    endtask

    task automatic test_random_settings;
        for (int phase = 0; phase < 12; phase++) begin
            write_reg(rpa_pkg::REG_PIVOT_X,
                      phase == 0 ? 32'h8000_0000 : $urandom >> $urandom_range(0, 12));
            write_reg(rpa_pkg::REG_PIVOT_Y,
                      phase == 0 ? 32'h7FFF_FFFF : $urandom >> $urandom_range(0, 12));
            write_reg(rpa_pkg::REG_PIVOT_Z, $urandom);
            write_reg(rpa_pkg::REG_AXIS_X, phase == 1 ? -18'sd65536 : pick_unit_axis());
            write_reg(rpa_pkg::REG_AXIS_Y, phase == 1 ? -18'sd65536 : pick_unit_axis());
            write_reg(rpa_pkg::REG_AXIS_Z, phase == 1 ? -18'sd65536 : pick_unit_axis());
            stall_free = (phase % 4 == 3);
            for (int k = 0; k < 75; k++)
                send_point(pick_point(), $urandom);
            drain();
        end
        stall_free = 1'b0;
    endtask

    // Result side: before each result, hold off for a random number of cycles, except in stall-free phases.
    always begin
        m_wait = stall_free ? 0 : $urandom_range(0, 14);
        if (m_wait > 0) begin
            m_tready <= 1'b0;
            repeat (m_wait) @(negedge aclk);
        end
        m_tready <= 1'b1;
        do @(posedge aclk); while (!m_tvalid);
        @(negedge aclk);
    end

    // Each accepted result is matched against the oldest prediction.
    always @(posedge aclk) begin
        point_t want, got;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (rotated_pending.size() == 0) begin
                $display("%0t: result with no item outstanding, got %h", $time, got);
                errors++;
            end else begin
                want = rotated_pending.pop_front();
                if (got.x !== want.x) begin
                    $display("%0t: rot_x expected %h actual %h", $time, want.x, got.x);
                    errors++;
                end
                if (got.y !== want.y) begin
                    $display("%0t: rot_y expected %h actual %h", $time, want.y, got.y);
                    errors++;
                end
                if (got.z !== want.z) begin
                    $display("%0t: rot_z expected %h actual %h", $time, want.z, got.z);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_rotate_point_about_axis: errors");
            $finish;
        end
    end

    initial begin
        pivot_q = '{0, 0, 0};
        axis_u = '{0, 0, 65536};
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_default_axis();
        drain();
        test_saturation();
        test_random_settings();
        drain();
        if (errors == 0)
            $display("tb_rotate_point_about_axis: clean");
        else
            $display("tb_rotate_point_about_axis: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rpa_pkg.sv
rtl/rpa_cordic.sv
rtl/rpa_geom.sv
rtl/rotate_point_about_axis.sv
sim/tb_rotate_point_about_axis.sv
